// File: design/fgcc_pkg.sv
// Shared types, constants and tables for the footprint grid collision check.
// Used by every module of the block but fgcc_ram; depends on nothing.
package fgcc_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int CORDIC_STEPS = 14;
  localparam int CORDIC_START = 39797;
  localparam int QDEPTH = 2;
  localparam int IN_DATA_W = 80;
  localparam int OUT_DATA_W = 8;

  // func codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_CELL_EDGE = 3'd2;
  localparam logic [2:0] REG_HALF_WIDTH = 3'd3;
  localparam logic [2:0] REG_AXLE = 3'd4;
  localparam logic [2:0] REG_ROWS = 3'd5;
  localparam logic [2:0] REG_COLS = 3'd6;

  typedef struct packed {
    logic              is_query;
    logic [5:0]        cell_row;
    logic [5:0]        cell_col;
    logic              cell_busy;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [15:0]       heading;
  } item_t;

  typedef struct packed {
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic [15:0]        cell_edge;
    logic [15:0]        half_car_width;
    logic [15:0]        axle_spacing;
    logic [6:0]         rows_in_use;
    logic [6:0]         cols_in_use;
  } cfg_t;

  // CORDIC arctangent steps, 65536 = full turn
  function automatic logic [13:0] atan_step(input logic [3:0] i);
    logic [13:0] v;
    case (i)
      4'd0:  v = 14'd8192;
      4'd1:  v = 14'd4836;
      4'd2:  v = 14'd2555;
      4'd3:  v = 14'd1297;
      4'd4:  v = 14'd651;
      4'd5:  v = 14'd326;
      4'd6:  v = 14'd163;
      4'd7:  v = 14'd81;
      4'd8:  v = 14'd41;
      4'd9:  v = 14'd20;
      4'd10: v = 14'd10;
      4'd11: v = 14'd5;
      4'd12: v = 14'd3;
      4'd13: v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

// File: design/footprint_grid_collision_check_core.sv
// Top level: APB register file, input queue and execution engine.
// Depends on fgcc_pkg, fgcc_front, fgcc_back (and fgcc_ram below it).
//
// Requests arrive on the s_axis channel: tuser is func (0 writes one grid
// cell, 1 asks a collision query for a pose). Every request gives exactly one
// response on m_axis: tdata[0] is hit, tuser is the echoed func.
// A cell write is popped and goes through ST_DONE to the output register. A
// query is popped, then runs 14 CORDIC steps, 6 products, 2 box states,
// 4 index divisions, the scan setup and the output; the scan reads each
// cell of the clamped bounding box and tests each occupied cell. The single
// shared multiplier and the one-read-port grid memory set its length. The
// front queue holds two requests, so requests are still taken while a query
// runs or a response waits.
// After reset the grid memory is cleared one cell per cycle;
// s_axis_tready stays low until it is cleared, while register writes are taken.
// When the receiver holds m_axis_tready low the response waits in the
// output register and the engine stops once it has its next response ready.
// The user must write registers through APB only while the block is idle; the block does not enforce it.
module footprint_grid_collision_check_core import fgcc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [5:0] cell_row, [11:6] cell_col, [12] cell_busy, [36:13] pos_x,
  // [60:37] pos_y, [76:61] heading, [79:77] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] func
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] hit, [7:1] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] reply_kind
  output logic [0:0]            m_axis_tuser,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t  cfg_q;
  item_t head;
  logic  head_valid, pop, run, hit, kind;
  logic  wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x       <= '0;
      cfg_q.origin_y       <= '0;
      cfg_q.cell_edge      <= 16'd256;
      cfg_q.half_car_width <= 16'd256;
      cfg_q.axle_spacing   <= 16'd640;
      cfg_q.rows_in_use    <= 7'd64;
      cfg_q.cols_in_use    <= 7'd64;
    end else if (wr) begin
      case (paddr[4:2])
        REG_ORIGIN_X:   cfg_q.origin_x       <= pwdata[23:0];
        REG_ORIGIN_Y:   cfg_q.origin_y       <= pwdata[23:0];
        REG_CELL_EDGE:  cfg_q.cell_edge      <= pwdata[15:0];
        REG_HALF_WIDTH: cfg_q.half_car_width <= pwdata[15:0];
        REG_AXLE:       cfg_q.axle_spacing   <= pwdata[15:0];
        REG_ROWS:       cfg_q.rows_in_use    <= pwdata[6:0];
        REG_COLS:       cfg_q.cols_in_use    <= pwdata[6:0];
        default:        cfg_q                <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_ORIGIN_X:   prdata = {8'b0, cfg_q.origin_x};
      REG_ORIGIN_Y:   prdata = {8'b0, cfg_q.origin_y};
      REG_CELL_EDGE:  prdata = {16'b0, cfg_q.cell_edge};
      REG_HALF_WIDTH: prdata = {16'b0, cfg_q.half_car_width};
      REG_AXLE:       prdata = {16'b0, cfg_q.axle_spacing};
      REG_ROWS:       prdata = {25'b0, cfg_q.rows_in_use};
      REG_COLS:       prdata = {25'b0, cfg_q.cols_in_use};
      default:        prdata = '0;
    endcase
  end

  fgcc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .run_i        (run),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  fgcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (head),
    .item_valid_i(head_valid),
    .item_pop_o  (pop),
    .run_o       (run),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_hit_o   (hit),
    .res_kind_o  (kind)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-1){1'b0}}, hit};
  assign m_axis_tuser = kind;

endmodule

// File: design/fgcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fgcc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/fgcc_front.sv
// Input side: accepts stream requests, decodes them and holds them in a short queue.
// Depends on fgcc_pkg.
module fgcc_front import fgcc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 run_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [5:0] cell_row, [11:6] cell_col, [12] cell_busy, [36:13] pos_x,
  // [60:37] pos_y, [76:61] heading, [79:77] zero
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  // [0] func
  input  logic [0:0]           s_axis_tuser,
  output item_t                head_o,
  output logic                 head_valid_o,
  input  logic                 pop_i
);

  localparam int PW = $clog2(QDEPTH);

  item_t           slot_q [QDEPTH];
  logic [PW-1:0]   wp_q, rp_q;
  logic [PW:0]     cnt_q;
  item_t           dec;
  logic            push;

  always_comb begin
    dec.is_query  = (s_axis_tuser[0] == FUNC_QUERY);
    dec.cell_row  = s_axis_tdata[5:0];
    dec.cell_col  = s_axis_tdata[11:6];
    dec.cell_busy = s_axis_tdata[12];
    dec.pos_x     = s_axis_tdata[36:13];
    dec.pos_y     = s_axis_tdata[60:37];
    dec.heading   = s_axis_tdata[76:61];
  end

  assign s_axis_tready = run_i && (cnt_q != (PW+1)'(QDEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign head_o        = slot_q[rp_q];
  assign head_valid_o  = (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      case ({push, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= dec;
    end
  end

endmodule

// File: design/fgcc_back.sv
// Execution side: grid writes, CORDIC, box extents, index division and cell scan.
// Depends on fgcc_pkg and fgcc_ram.
module fgcc_back import fgcc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  item_t item_i,
  input  logic  item_valid_i,
  output logic  item_pop_o,
  output logic  run_o,
  output logic  res_valid_o,
  input  logic  res_ready_i,
  output logic  res_hit_o,
  output logic  res_kind_o
);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_CORD, ST_PROD, ST_EXT1, ST_EXT2, ST_DLOAD, ST_DIV,
    ST_DPOST, ST_SCAN0, ST_RD, ST_CHK, ST_TEST, ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [4:0] step_q, step_d;
  logic [1:0] jd_q, jd_d;
  logic out_valid_q, out_valid_d;

  item_t item_q, item_d;
  logic signed [17:0] z_q, z_d;
  logic signed [18:0] x_q, x_d, y_q, y_d, c_q, c_d, s_q, s_d;
  logic flip_q, flip_d;
  logic signed [37:0] p_q [6];
  logic signed [37:0] p_d [6];
  logic signed [39:0] ext_q [4];
  logic signed [39:0] ext_d [4];
  logic signed [26:0] num_q [4];
  logic signed [26:0] num_d [4];
  logic [15:0] rem_q, rem_d;
  logic [26:0] quo_q, quo_d;
  logic signed [8:0] idx_q [4];
  logic signed [8:0] idx_d [4];
  logic [ROW_W-1:0] r_q, r_d;
  logic [COL_W-1:0] k_q, k_d;
  logic [22:0] kc_q, kc_d, rc_q, rc_d;
  logic signed [27:0] dx_q, dx_d, dy_q, dy_d;
  logic signed [47:0] pr_q [4];
  logic signed [47:0] pr_d [4];
  logic signed [48:0] bx_q, bx_d, by_q, by_d;
  logic hit_q, hit_d, out_hit_q, out_hit_d, out_kind_q, out_kind_d;

  // derived footprint
  logic [15:0] cell_e;
  logic [17:0] hw, fwd, rev;
  logic [6:0] rows_l, cols_l;

  assign cell_e = (cfg_i.cell_edge == '0) ? 16'd1 : cfg_i.cell_edge;
  assign hw     = {2'b0, cfg_i.half_car_width} + {2'b0, cell_e};
  assign fwd    = {2'b0, cfg_i.axle_spacing} + 18'd128 + {2'b0, cell_e};
  assign rev    = 18'd128 + {2'b0, cell_e};
  assign rows_l = (cfg_i.rows_in_use > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : cfg_i.rows_in_use;
  assign cols_l = (cfg_i.cols_in_use > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cfg_i.cols_in_use;

  // shared multiplier
  logic signed [19:0] mul_a;
  logic signed [27:0] mul_b;
  logic signed [47:0] mul_p;
  logic signed [19:0] c20, s20;
  logic signed [27:0] fwd28, rev28, hw28, cell28;

  assign c20    = {c_q[18], c_q};
  assign s20    = {s_q[18], s_q};
  assign fwd28  = $signed({10'b0, fwd});
  assign rev28  = $signed({10'b0, rev});
  assign hw28   = $signed({10'b0, hw});
  assign cell28 = $signed({12'b0, cell_e});
  assign mul_p  = mul_a * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_PROD: begin
        case (step_q[2:0])
          3'd0:    begin mul_a = c20; mul_b = fwd28; end
          3'd1:    begin mul_a = c20; mul_b = rev28; end
          3'd2:    begin mul_a = s20; mul_b = fwd28; end
          3'd3:    begin mul_a = s20; mul_b = rev28; end
          3'd4:    begin mul_a = c20; mul_b = hw28; end
          3'd5:    begin mul_a = s20; mul_b = hw28; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_TEST: begin
        case (step_q[3:0])
          4'd0:    begin mul_a = $signed({14'b0, k_q}); mul_b = cell28; end
          4'd1:    begin mul_a = $signed({14'b0, r_q}); mul_b = cell28; end
          4'd3:    begin mul_a = c20; mul_b = dx_q; end
          4'd4:    begin mul_a = s20; mul_b = dy_q; end
          4'd5:    begin mul_a = c20; mul_b = dy_q; end
          4'd6:    begin mul_a = s20; mul_b = dx_q; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // occupancy memory
  logic ram_we, ram_wdata, ram_rdata;
  logic [ADDR_W-1:0] ram_waddr;

  fgcc_ram #(
    .WIDTH(1),
    .DEPTH(CELLS)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i({r_q, k_q}),
    .rdata_o(ram_rdata)
  );

  // CORDIC step
  logic signed [18:0] xs, ys, x_n, y_n;
  logic signed [17:0] z_n, at18, z0;

  assign xs   = x_q >>> step_q[3:0];
  assign ys   = y_q >>> step_q[3:0];
  assign at18 = $signed({4'b0, atan_step(step_q[3:0])});
  assign x_n  = z_q[17] ? x_q + ys : x_q - ys;
  assign y_n  = z_q[17] ? y_q - xs : y_q + xs;
  assign z_n  = z_q[17] ? z_q + at18 : z_q - at18;
  assign z0   = $signed({{2{item_i.heading[15]}}, item_i.heading});

  // extents
  logic signed [39:0] e_cf, e_ncr, e_sf, e_nsr, e_ash, e_ach;
  assign e_cf  = 40'(p_q[0]);
  assign e_ncr = -40'(p_q[1]);
  assign e_sf  = 40'(p_q[2]);
  assign e_nsr = -40'(p_q[3]);
  assign e_ach = p_q[4][37] ? -40'(p_q[4]) : 40'(p_q[4]);
  assign e_ash = p_q[5][37] ? -40'(p_q[5]) : 40'(p_q[5]);

  // division post-processing
  logic [7:0] qsat;
  logic signed [8:0] dval, limm1;
  logic nneg;
  logic signed [26:0] nsel;
  logic [6:0] lim;

  assign nsel  = num_q[jd_q];
  assign nneg  = nsel[26];
  assign qsat  = (|quo_q[26:7]) ? 8'd127 : {1'b0, quo_q[6:0]};
  assign lim   = jd_q[1] ? rows_l : cols_l;
  assign limm1 = $signed({2'b0, lim}) - 9'sd1;

  always_comb begin
    if (!jd_q[0]) begin
      dval = nneg ? 9'sd0 : $signed({1'b0, qsat});
    end else if (nneg) begin
      dval = (quo_q == '0) ? 9'sd0 : -9'sd1;
    end else begin
      dval = $signed({1'b0, qsat}) + $signed({8'b0, (rem_q != '0)});
    end
    if (jd_q[0] && (dval > limm1)) begin
      dval = limm1;
    end
  end

  // scan end
  logic last_k, last_r;
  assign last_k = (k_q == idx_q[1][COL_W-1:0]);
  assign last_r = (r_q == idx_q[3][ROW_W-1:0]);

  logic [16:0] trial;
  logic ge;
  assign trial = {rem_q, quo_q[26]};
  assign ge    = (trial >= {1'b0, cell_e});

  logic signed [27:0] ddx, ddy;
  assign ddx = 28'(cfg_i.origin_x) - 28'(item_q.pos_x);
  assign ddy = 28'(cfg_i.origin_y) - 28'(item_q.pos_y);

  logic signed [48:0] t_fwd, t_rev, t_hw;
  assign t_fwd = $signed({14'b0, fwd, 17'b0});
  assign t_rev = $signed({14'b0, rev, 17'b0});
  assign t_hw  = $signed({14'b0, hw, 17'b0});

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    step_d = step_q;
    jd_d = jd_q;
    out_valid_d = out_valid_q;
    out_hit_d = out_hit_q;
    out_kind_d = out_kind_q;
    item_d = item_q;
    z_d = z_q; x_d = x_q; y_d = y_q; c_d = c_q; s_d = s_q; flip_d = flip_q;
    p_d = p_q; ext_d = ext_q; num_d = num_q; idx_d = idx_q; pr_d = pr_q;
    rem_d = rem_q; quo_d = quo_q;
    r_d = r_q; k_d = k_q; kc_d = kc_q; rc_d = rc_q;
    dx_d = dx_q; dy_d = dy_q; bx_d = bx_q; by_d = by_q;
    hit_d = hit_q;
    item_pop_o = 1'b0;
    ram_we = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = 1'b0;

    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLR: begin
        ram_we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == ADDR_W'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          item_d = item_i;
          hit_d = 1'b0;
          if (!item_i.is_query) begin
            ram_we = 1'b1;
            ram_waddr = {item_i.cell_row, item_i.cell_col};
            ram_wdata = item_i.cell_busy;
            state_d = ST_DONE;
          end else begin
            x_d = 19'sd39797;
            y_d = '0;
            step_d = '0;
            if (z0 > 18'sd16384) begin
              z_d = z0 - 18'sd32768;
              flip_d = 1'b1;
            end else if (z0 < -18'sd16384) begin
              z_d = z0 + 18'sd32768;
              flip_d = 1'b1;
            end else begin
              z_d = z0;
              flip_d = 1'b0;
            end
            state_d = ST_CORD;
          end
        end
      end
      ST_CORD: begin
        x_d = x_n;
        y_d = y_n;
        z_d = z_n;
        step_d = step_q + 1'b1;
        if (step_q == 5'(CORDIC_STEPS - 1)) begin
          c_d = flip_q ? -x_n : x_n;
          s_d = flip_q ? -y_n : y_n;
          step_d = '0;
          state_d = ST_PROD;
        end
      end
      ST_PROD: begin
        case (step_q[2:0])
          3'd0:    p_d[0] = mul_p[37:0];
          3'd1:    p_d[1] = mul_p[37:0];
          3'd2:    p_d[2] = mul_p[37:0];
          3'd3:    p_d[3] = mul_p[37:0];
          3'd4:    p_d[4] = mul_p[37:0];
          3'd5:    p_d[5] = mul_p[37:0];
          default: p_d[0] = p_q[0];
        endcase
        step_d = step_q + 1'b1;
        if (step_q == 5'd5) begin
          step_d = '0;
          state_d = ST_EXT1;
        end
      end
      ST_EXT1: begin
        ext_d[0] = ((e_cf < e_ncr) ? e_cf : e_ncr) - e_ash;
        ext_d[1] = ((e_cf < e_ncr) ? e_ncr : e_cf) + e_ash;
        ext_d[2] = ((e_sf < e_nsr) ? e_sf : e_nsr) - e_ach;
        ext_d[3] = ((e_sf < e_nsr) ? e_nsr : e_sf) + e_ach;
        state_d = ST_EXT2;
      end
      ST_EXT2: begin
        // low edges floor, high edges ceil, in units of 2^-8 m
        num_d[0] = 27'($signed(ext_q[0][39:16])) + 27'(item_q.pos_x)
                   - 27'(cfg_i.origin_x);
        num_d[1] = 27'($signed(ext_q[1] + 40'sd65535) >>> 16)
                   + 27'(item_q.pos_x) - 27'(cfg_i.origin_x);
        num_d[2] = 27'($signed(ext_q[2][39:16])) + 27'(item_q.pos_y)
                   - 27'(cfg_i.origin_y);
        num_d[3] = 27'($signed(ext_q[3] + 40'sd65535) >>> 16)
                   + 27'(item_q.pos_y) - 27'(cfg_i.origin_y);
        jd_d = '0;
        state_d = ST_DLOAD;
      end
      ST_DLOAD: begin
        rem_d = '0;
        quo_d = nsel[26] ? 27'(-nsel) : 27'(nsel);
        step_d = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = ge ? 16'(trial - {1'b0, cell_e}) : trial[15:0];
        quo_d = {quo_q[25:0], ge};
        step_d = step_q + 1'b1;
        if (step_q == 5'd26) begin
          state_d = ST_DPOST;
        end
      end
      ST_DPOST: begin
        idx_d[jd_q] = dval;
        jd_d = jd_q + 1'b1;
        state_d = (jd_q == 2'd3) ? ST_SCAN0 : ST_DLOAD;
      end
      ST_SCAN0: begin
        r_d = idx_q[2][ROW_W-1:0];
        k_d = idx_q[0][COL_W-1:0];
        if ((idx_q[1] < idx_q[0]) || (idx_q[3] < idx_q[2])) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (ram_rdata) begin
          step_d = '0;
          state_d = ST_TEST;
        end else if (last_k && last_r) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_RD;
          if (last_k) begin
            k_d = idx_q[0][COL_W-1:0];
            r_d = r_q + 1'b1;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      ST_TEST: begin
        step_d = step_q + 1'b1;
        case (step_q[3:0])
          4'd0: kc_d = mul_p[22:0];
          4'd1: rc_d = mul_p[22:0];
          4'd2: begin
            // cell centre minus pose, units of 2^-9 m
            dx_d = {ddx[26:0], 1'b0} + $signed({4'b0, kc_q, 1'b0}) + cell28;
            dy_d = {ddy[26:0], 1'b0} + $signed({4'b0, rc_q, 1'b0}) + cell28;
          end
          4'd3: pr_d[0] = mul_p;
          4'd4: pr_d[1] = mul_p;
          4'd5: pr_d[2] = mul_p;
          4'd6: pr_d[3] = mul_p;
          4'd7: begin
            bx_d = 49'(pr_q[0]) + 49'(pr_q[1]);
            by_d = 49'(pr_q[2]) - 49'(pr_q[3]);
          end
          default: begin
            if ((bx_q >= -t_rev) && (bx_q <= t_fwd) && (by_q >= -t_hw) && (by_q <= t_hw)) begin
              hit_d = 1'b1;
              state_d = ST_DONE;
            end else if (last_k && last_r) begin
              state_d = ST_DONE;
            end else begin
              state_d = ST_RD;
              if (last_k) begin
                k_d = idx_q[0][COL_W-1:0];
                r_d = r_q + 1'b1;
              end else begin
                k_d = k_q + 1'b1;
              end
            end
          end
        endcase
      end
      ST_DONE: begin
        if (!out_valid_q || res_ready_i) begin
          out_valid_d = 1'b1;
          out_hit_d = hit_q;
          out_kind_d = item_q.is_query;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      clr_q <= '0;
      step_q <= '0;
      jd_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      step_q <= step_d;
      jd_q <= jd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    z_q <= z_d; x_q <= x_d; y_q <= y_d; c_q <= c_d; s_q <= s_d; flip_q <= flip_d;
    p_q <= p_d; ext_q <= ext_d; num_q <= num_d; idx_q <= idx_d; pr_q <= pr_d;
    rem_q <= rem_d; quo_q <= quo_d;
    r_q <= r_d; k_q <= k_d; kc_q <= kc_d; rc_q <= rc_d;
    dx_q <= dx_d; dy_q <= dy_d; bx_q <= bx_d; by_q <= by_d;
    hit_q <= hit_d;
    out_hit_q <= out_hit_d;
    out_kind_q <= out_kind_d;
  end

  assign run_o       = (state_q != ST_CLR);
  assign res_valid_o = out_valid_q;
  assign res_hit_o   = out_hit_q;
  assign res_kind_o  = out_kind_q;

endmodule
